### hw/rtl/tspc_pkg.sv
// shared types and constants for the tile sprite pixel compositor
package tspc_pkg;

    localparam logic [2:0] OP_OBJ_TILE_WR = 3'd0;
    localparam logic [2:0] OP_BG_TILE_WR  = 3'd1;
    localparam logic [2:0] OP_OBJ_PAL_WR  = 3'd2;
    localparam logic [2:0] OP_BG_PAL_WR   = 3'd3;
    localparam logic [2:0] OP_DRAW_OBJ    = 3'd4;
    localparam logic [2:0] OP_DRAW_BG     = 3'd5;

    localparam logic CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic CFG_CANVAS_HEIGHT = 1'b1;

    localparam logic [9:0] CANVAS_WIDTH_RESET  = 10'd240;
    localparam logic [9:0] CANVAS_HEIGHT_RESET = 10'd160;

    // background range tiles are two tiles wide
    localparam int unsigned RANGE_STRIDE = 2;
    // shift of the fixed-point reciprocal used for the tile wrap
    localparam int unsigned MOD_SHIFT = 22;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        draw_ok;
        logic        hi_nibble;
        logic [3:0]  pal_bank;
        logic [23:0] under_pixel;
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [7:0]  palette_address;
        logic [14:0] write_data;
        logic [10:0] tile_sum;
        logic [5:0]  tile_quot;
        logic [4:0]  byte_offset;
        logic [3:0]  pix_index;
    } stage_t;

endpackage

### hw/rtl/tile_sprite_pixel_compositor.sv
// top level: tile fetch, palette lookup, color expansion, blend and clip pipeline
// an accepted item passes s1_reg, s2_reg and s3_reg, then the output register
// one item per cycle unless held; each item, write or draw, gives one result
// a stalled output holds the whole pipeline in place, input stall follows at once
// reset clears the valid bits and sets the canvas to 240 x 160
// tile and palette memories are not cleared by reset; read only what was written
module tile_sprite_pixel_compositor
    import tspc_pkg::*;
#(
    parameter int TILE_COUNT      = 1024,
    parameter int TILE_ROW_STRIDE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [14:0] write_address,
    input  logic [15:0] write_data,
    input  logic [4:0]  local_x,
    input  logic [4:0]  local_y,
    input  logic signed [10:0] dest_x,
    input  logic signed [10:0] dest_y,
    input  logic [9:0]  first_tile,
    input  logic [3:0]  pal_bank,
    input  logic [23:0] under_pixel,
    // result item channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pixel_write,
    output logic [9:0]  pixel_x,
    output logic [9:0]  pixel_y,
    output logic [23:0] pixel_color,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data
);

    // tile store geometry
    localparam int TILE_W     = $clog2(TILE_COUNT);
    localparam int STORE_DEPTH = TILE_COUNT * 32;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    // reciprocal of the tile count; exact for every 11-bit tile sum
    localparam logic [27:0] RECIP =
        28'(((64'd1 << MOD_SHIFT) + 64'(TILE_COUNT) - 64'd1) / 64'(TILE_COUNT));

    // canvas size registers
    logic [9:0] canvas_width_reg;
    logic [9:0] canvas_height_reg;

    // pipeline registers and their valid bits
    stage_t s1_reg, s2_reg, s3_reg;
    stage_t s1_next, s2_next, s3_next;
    logic   s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;

    logic        pixel_write_reg, pixel_write_next;
    logic [9:0]  pixel_x_reg, pixel_x_next;
    logic [9:0]  pixel_y_reg, pixel_y_next;
    logic [23:0] pixel_color_reg, pixel_color_next;

    // the whole pipeline moves together unless a finished result is held
    logic advance;
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= CANVAS_WIDTH_RESET;
            canvas_height_reg <= CANVAS_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data;
                CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data;
                default:           canvas_width_reg  <= canvas_width_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 0: decode, clip, tile sum and reciprocal estimate of the wrap
    // ------------------------------------------------------------------
    logic        is_draw_in;
    logic        is_bg_in;
    logic        on_canvas;
    logic [10:0] stride_in;
    logic [10:0] mod_value;
    logic [27:0] mod_product;

    always_comb
    begin
        is_draw_in = (opcode == OP_DRAW_OBJ) || (opcode == OP_DRAW_BG);
        is_bg_in   = (opcode == OP_DRAW_BG);
        stride_in  = is_bg_in ? 11'(RANGE_STRIDE) : 11'(TILE_ROW_STRIDE);
        // negative positions drop, and so does anything at or past the edge
        on_canvas  = !dest_x[10] && !dest_y[10]
                     && (dest_x[9:0] < canvas_width_reg)
                     && (dest_y[9:0] < canvas_height_reg);

        if (is_draw_in)
        begin
            mod_value = {1'b0, first_tile} + 11'(local_y[4:3]) * stride_in
                        + 11'(local_x[4:3]);
        end
        else
        begin
            mod_value = {1'b0, write_address[14:5]};
        end
        mod_product = 28'(mod_value) * RECIP;

        s1_next                 = '0;
        s1_next.opcode          = opcode;
        s1_next.draw_ok         = is_draw_in && on_canvas;
        s1_next.hi_nibble       = local_x[0];
        s1_next.pal_bank        = pal_bank;
        s1_next.under_pixel     = under_pixel;
        s1_next.pixel_x         = dest_x[9:0];
        s1_next.pixel_y         = dest_y[9:0];
        s1_next.palette_address = write_address[7:0];
        s1_next.write_data      = write_data[14:0];
        s1_next.tile_sum        = mod_value;
        s1_next.tile_quot       = mod_product[27:22];
        s1_next.byte_offset     = is_draw_in ? {local_y[2:0], local_x[2:1]}
                                             : write_address[4:0];
    end

    // ------------------------------------------------------------------
    // stage 1: finish the wrap, tile memory write or read
    // ------------------------------------------------------------------
    logic [10:0]       tile_rem;
    logic [ADDR_W-1:0] tile_addr;
    logic [7:0]        obj_tile_byte;
    logic [7:0]        bg_tile_byte;
    logic              obj_tile_we;
    logic              bg_tile_we;

    always_comb
    begin
        tile_rem    = s1_reg.tile_sum - 11'(s1_reg.tile_quot * 11'(TILE_COUNT));
        tile_addr   = ADDR_W'({tile_rem[TILE_W-1:0], s1_reg.byte_offset});
        obj_tile_we = advance && s1_valid_reg && (s1_reg.opcode == OP_OBJ_TILE_WR);
        bg_tile_we  = advance && s1_valid_reg && (s1_reg.opcode == OP_BG_TILE_WR);
    end

    tspc_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_obj_tile_ram (
        .clk   (clk),
        .we    (obj_tile_we),
        .waddr (tile_addr),
        .wdata (s1_reg.write_data[7:0]),
        .re    (advance),
        .raddr (tile_addr),
        .rdata (obj_tile_byte)
    );

    tspc_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_bg_tile_ram (
        .clk   (clk),
        .we    (bg_tile_we),
        .waddr (tile_addr),
        .wdata (s1_reg.write_data[7:0]),
        .re    (advance),
        .raddr (tile_addr),
        .rdata (bg_tile_byte)
    );

    assign s2_next = s1_reg;

    // ------------------------------------------------------------------
    // stage 2: nibble pick, transparency, palette write or read
    // ------------------------------------------------------------------
    logic [7:0]  packed_byte;
    logic [3:0]  pix_index;
    logic [7:0]  pal_addr;
    logic [14:0] obj_pal_color;
    logic [14:0] bg_pal_color;
    logic        obj_pal_we;
    logic        bg_pal_we;

    always_comb
    begin
        packed_byte = (s2_reg.opcode == OP_DRAW_BG) ? bg_tile_byte : obj_tile_byte;
        pix_index   = s2_reg.hi_nibble ? packed_byte[7:4] : packed_byte[3:0];
        pal_addr    = s2_reg.draw_ok ? {s2_reg.pal_bank, pix_index}
                                     : s2_reg.palette_address;
        obj_pal_we  = advance && s2_valid_reg && (s2_reg.opcode == OP_OBJ_PAL_WR);
        bg_pal_we   = advance && s2_valid_reg && (s2_reg.opcode == OP_BG_PAL_WR);

        s3_next           = s2_reg;
        s3_next.pix_index = pix_index;
        // index zero is transparent
        s3_next.draw_ok   = s2_reg.draw_ok && (pix_index != 4'd0);
    end

    tspc_ram #(
        .WIDTH (15),
        .DEPTH (256)
    ) u_obj_pal_ram (
        .clk   (clk),
        .we    (obj_pal_we),
        .waddr (pal_addr),
        .wdata (s2_reg.write_data),
        .re    (advance),
        .raddr (pal_addr),
        .rdata (obj_pal_color)
    );

    tspc_ram #(
        .WIDTH (15),
        .DEPTH (256)
    ) u_bg_pal_ram (
        .clk   (clk),
        .we    (bg_pal_we),
        .waddr (pal_addr),
        .wdata (s2_reg.write_data),
        .re    (advance),
        .raddr (pal_addr),
        .rdata (bg_pal_color)
    );

    // ------------------------------------------------------------------
    // stage 3: bgr555 to rgb888, 10:6 blend for background draws
    // ------------------------------------------------------------------
    function automatic logic [7:0] expand5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    // (top*10 + under*6) / 16, never above 255
    function automatic logic [7:0] blend_ch(input logic [7:0] t, input logic [7:0] u);
        logic [11:0] sum;
        sum = 12'(t) * 12'd10 + 12'(u) * 12'd6;
        return sum[11:4];
    endfunction

    logic [14:0] pal_color;
    logic [23:0] top_rgb;
    logic [23:0] final_rgb;

    always_comb
    begin
        pal_color = (s3_reg.opcode == OP_DRAW_BG) ? bg_pal_color : obj_pal_color;
        top_rgb   = {expand5(pal_color[14:10]), expand5(pal_color[9:5]),
                     expand5(pal_color[4:0])};
        if (s3_reg.opcode == OP_DRAW_BG)
        begin
            final_rgb = {blend_ch(top_rgb[23:16], s3_reg.under_pixel[23:16]),
                         blend_ch(top_rgb[15:8],  s3_reg.under_pixel[15:8]),
                         blend_ch(top_rgb[7:0],   s3_reg.under_pixel[7:0])};
        end
        else
        begin
            final_rgb = top_rgb;
        end

        // a dropped pixel reports all zero fields
        pixel_write_next = s3_reg.draw_ok;
        pixel_x_next     = s3_reg.draw_ok ? s3_reg.pixel_x : 10'd0;
        pixel_y_next     = s3_reg.draw_ok ? s3_reg.pixel_y : 10'd0;
        pixel_color_next = s3_reg.draw_ok ? final_rgb : 24'd0;
    end

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg          <= s1_next;
            s2_reg          <= s2_next;
            s3_reg          <= s3_next;
            pixel_write_reg <= pixel_write_next;
            pixel_x_reg     <= pixel_x_next;
            pixel_y_reg     <= pixel_y_next;
            pixel_color_reg <= pixel_color_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_write = pixel_write_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;

endmodule

### hw/rtl/tspc_ram.sv
// generic simple dual-port ram with registered read
module tspc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tspc_checker.sv
// port-level checks for the tile sprite pixel compositor, bound to the top level
module tspc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        pixel_write,
    input logic [9:0]  pixel_x,
    input logic [9:0]  pixel_y,
    input logic [23:0] pixel_color
);

    // a dropped pixel carries zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pixel_write) |-> (pixel_x == 10'd0 && pixel_y == 10'd0
                                         && pixel_color == 24'd0))
    else $error("dropped pixel with nonzero fields");

    // input is only held back by a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

    // an item that is taken reaches the output register when the output does not stall meanwhile
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
    else $error("result missing after pipeline latency");

    // a held result keeps its fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pixel_write)
                                      && $stable(pixel_x) && $stable(pixel_y)
                                      && $stable(pixel_color)))
    else $error("held result changed");

endmodule

bind tile_sprite_pixel_compositor tspc_checker u_tspc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_write (pixel_write),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color)
);

### verif/tile_sprite_pixel_compositor_tb.sv
// self-checking testbench for the tile sprite pixel compositor: directed and random items
`timescale 1ns / 1ps

module tile_sprite_pixel_compositor_tb
    import tspc_pkg::*;
();

    // store geometry at the default parameters of the block
    localparam int unsigned TILES          = 1024;
    localparam int unsigned OBJ_ROW_STRIDE = 32;
    localparam int unsigned TILE_BYTES     = 32;
    localparam int unsigned STORE_BYTES    = TILES * TILE_BYTES;

    // opcodes the block must ignore
    localparam logic [2:0] OP_UNUSED_A = 3'd6;
    localparam logic [2:0] OP_UNUSED_B = 3'd7;

    // long output hold used to back the pipeline up into the input
    localparam int HOLD_CYCLES = 120;

    // one input item, field for field as on the ports
    typedef struct {
        logic [2:0]         opcode;
        logic [14:0]        write_address;
        logic [15:0]        write_data;
        logic [4:0]         local_x;
        logic [4:0]         local_y;
        logic signed [10:0] dest_x;
        logic signed [10:0] dest_y;
        logic [9:0]         first_tile;
        logic [3:0]         pal_bank;
        logic [23:0]        under_pixel;
    } comp_item_t;

    // one result item
    typedef struct {
        logic        write_en;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [23:0] color;
    } pixel_t;

    // byte address of the 4bpp pair that holds a pixel of an object or range tile
    function automatic logic [14:0] tile_byte_addr(bit bg, logic [9:0] base,
                                                   logic [4:0] lx, logic [4:0] ly);
        int unsigned col;
        int unsigned row;
        int unsigned stride;
        int unsigned tile;
        col    = lx;
        row    = ly;
        stride = bg ? RANGE_STRIDE : OBJ_ROW_STRIDE;
        tile   = (base + (row >> 3) * stride + (col >> 3)) % TILES;
        return 15'((tile * TILE_BYTES + (row & 7) * 4 + (col & 7) / 2) % STORE_BYTES);
    endfunction

    // shadow of the tile and palette stores plus the queue of pixels still to come out
    class pixel_scoreboard;
        logic [7:0]  obj_tiles    [0:32767];
        logic [7:0]  bg_tiles     [0:32767];
        bit          obj_tile_set [0:32767];
        bit          bg_tile_set  [0:32767];
        logic [14:0] obj_pal      [0:255];
        logic [14:0] bg_pal       [0:255];
        bit          obj_pal_set  [0:255];
        bit          bg_pal_set   [0:255];
        int          canvas_w;
        int          canvas_h;
        pixel_t      pending_pixels [$];
        int          mismatches;
        int          draws_seen;
        int          pixels_drawn;
        int          results_checked;

        function new();
            canvas_w = CANVAS_WIDTH_RESET;
            canvas_h = CANVAS_HEIGHT_RESET;
        endfunction

        function void set_canvas(logic idx, logic [9:0] value);
            if (idx == CFG_CANVAS_WIDTH)
                canvas_w = value;
            else
                canvas_h = value;
        endfunction

        function logic [23:0] expand_bgr555(logic [14:0] c);
            return {c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
        endfunction

        // 10:6 mix per channel, truncated
        function logic [23:0] blend_over(logic [23:0] top, logic [23:0] under);
            logic [23:0] mix;
            int t;
            int u;
            for (int k = 0; k < 3; k++)
            begin
                t = top[8*k +: 8];
                u = under[8*k +: 8];
                mix[8*k +: 8] = 8'((t * 10 + u * 6) / 16);
            end
            return mix;
        endfunction

        function pixel_t predict_pixel(comp_item_t it);
            pixel_t      px;
            bit          bg;
            int          dx;
            int          dy;
            logic [14:0] addr;
            logic [7:0]  tile_byte;
            logic [3:0]  idx;
            logic [23:0] rgb;
            px = '{1'b0, 10'd0, 10'd0, 24'd0};
            dx = it.dest_x;
            dy = it.dest_y;
            case (it.opcode)
                OP_OBJ_TILE_WR:
                begin
                    obj_tiles[it.write_address]    = it.write_data[7:0];
                    obj_tile_set[it.write_address] = 1'b1;
                end
                OP_BG_TILE_WR:
                begin
                    bg_tiles[it.write_address]    = it.write_data[7:0];
                    bg_tile_set[it.write_address] = 1'b1;
                end
                OP_OBJ_PAL_WR:
                begin
                    obj_pal[it.write_address[7:0]]     = it.write_data[14:0];
                    obj_pal_set[it.write_address[7:0]] = 1'b1;
                end
                OP_BG_PAL_WR:
                begin
                    bg_pal[it.write_address[7:0]]     = it.write_data[14:0];
                    bg_pal_set[it.write_address[7:0]] = 1'b1;
                end
                OP_DRAW_OBJ, OP_DRAW_BG:
                begin
                    draws_seen++;
                    bg = (it.opcode == OP_DRAW_BG);
                    if (dx >= 0 && dy >= 0 && dx < canvas_w && dy < canvas_h)
                    begin
                        addr      = tile_byte_addr(bg, it.first_tile, it.local_x, it.local_y);
                        tile_byte = bg ? bg_tiles[addr] : obj_tiles[addr];
                        idx       = it.local_x[0] ? tile_byte[7:4] : tile_byte[3:0];
                        if (idx != 4'd0)
                        begin
                            rgb = expand_bgr555(bg ? bg_pal[{it.pal_bank, idx}]
                                                   : obj_pal[{it.pal_bank, idx}]);
                            if (bg)
                                rgb = blend_over(rgb, it.under_pixel);
                            px = '{1'b1, 10'(dx), 10'(dy), rgb};
                            pixels_drawn++;
                        end
                    end
                end
                default: ;
            endcase
            return px;
        endfunction

        function void note_item(comp_item_t it);
            pending_pixels.push_back(predict_pixel(it));
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            results_checked++;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel result: write=%0d x=%0d y=%0d color=%06h",
                             got.write_en, got.x, got.y, got.color);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.write_en !== want.write_en || got.x !== want.x ||
                got.y !== want.y || got.color !== want.color)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("pixel mismatch at result %0d: expected write=%0d x=%0d y=%0d color=%06h",
                             results_checked, want.write_en, want.x, want.y, want.color);
                    $display("    got write=%0d x=%0d y=%0d color=%06h",
                             got.write_en, got.x, got.y, got.color);
                end
            end
        endfunction
    endclass

    // clock, reset and the three channels
    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         opcode;
    logic [14:0]        write_address;
    logic [15:0]        write_data;
    logic [4:0]         local_x;
    logic [4:0]         local_y;
    logic signed [10:0] dest_x;
    logic signed [10:0] dest_y;
    logic [9:0]         first_tile;
    logic [3:0]         pal_bank;
    logic [23:0]        under_pixel;
    logic               out_valid;
    logic               out_stall;
    logic               pixel_write;
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
    logic [23:0]        pixel_color;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [9:0]         cfg_data;

    pixel_scoreboard sb;
    bit              idle_on;        // both sides insert random gaps while set
    int              items_sent;
    int              holds_done;
    int              settings_used;

    tile_sprite_pixel_compositor DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .write_address(write_address),
        .write_data   (write_data),
        .local_x      (local_x),
        .local_y      (local_y),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .first_tile   (first_tile),
        .pal_bank     (pal_bank),
        .under_pixel  (under_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_write  (pixel_write),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_color  (pixel_color),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 20 ns period
    always #10 clk = ~clk;

    // every field random but the opcode, which is an object draw; callers override what matters
    function automatic comp_item_t random_item();
        comp_item_t it;
        it.opcode        = OP_DRAW_OBJ;
        it.write_address = 15'($urandom);
        it.write_data    = 16'($urandom);
        it.local_x       = 5'($urandom);
        it.local_y       = 5'($urandom);
        it.dest_x        = 11'($urandom);
        it.dest_y        = 11'($urandom);
        it.first_tile    = 10'($urandom);
        it.pal_bank      = 4'($urandom);
        it.under_pixel   = 24'($urandom);
        return it;
    endfunction

    function automatic comp_item_t write_item(logic [2:0] op, logic [14:0] addr,
                                              logic [15:0] data);
        comp_item_t it;
        it               = random_item();
        it.opcode        = op;
        it.write_address = addr;
        it.write_data    = data;
        return it;
    endfunction

    function automatic comp_item_t draw_item(logic [2:0] op, logic [4:0] lx, logic [4:0] ly,
                                             logic [9:0] base, logic [3:0] bank,
                                             logic signed [10:0] dx, logic signed [10:0] dy,
                                             logic [23:0] under);
        comp_item_t it;
        it             = random_item();
        it.opcode      = op;
        it.local_x     = lx;
        it.local_y     = ly;
        it.first_tile  = base;
        it.pal_bank    = bank;
        it.dest_x      = dx;
        it.dest_y      = dy;
        it.under_pixel = under;
        return it;
    endfunction

    // mostly on the canvas, some just past its far edge, the rest anywhere in the signed range
    function automatic logic signed [10:0] pick_coord(int lim);
        int r;
        r = $urandom_range(0, 9);
        if (lim > 0 && r < 7)
            return 11'($urandom_range(0, lim - 1));
        else if (r < 8)
            return 11'(lim);
        else
            return 11'($urandom);
    endfunction

    // offer one item, hold it until taken, then let the scoreboard predict it
    task automatic send_item(comp_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode        <= it.opcode;
        write_address <= it.write_address;
        write_data    <= it.write_data;
        local_x       <= it.local_x;
        local_y       <= it.local_y;
        dest_x        <= it.dest_x;
        dest_y        <= it.dest_y;
        first_tile    <= it.first_tile;
        pal_bank      <= it.pal_bank;
        under_pixel   <= it.under_pixel;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_item(it);
        items_sent++;
    endtask

    // a draw only ever reads store entries that were written: missing ones are filled first
    task automatic draw_pixel(comp_item_t it);
        bit          bg;
        logic [14:0] addr;
        logic [7:0]  tile_byte;
        logic [3:0]  idx;
        logic [7:0]  entry;
        bg   = (it.opcode == OP_DRAW_BG);
        addr = tile_byte_addr(bg, it.first_tile, it.local_x, it.local_y);
        if (!(bg ? sb.bg_tile_set[addr] : sb.obj_tile_set[addr]))
            send_item(write_item(bg ? OP_BG_TILE_WR : OP_OBJ_TILE_WR, addr, 16'($urandom)));
        tile_byte = bg ? sb.bg_tiles[addr] : sb.obj_tiles[addr];
        idx       = it.local_x[0] ? tile_byte[7:4] : tile_byte[3:0];
        entry     = {it.pal_bank, idx};
        // the transparent entry is filled too, so no lookup ever hits an unwritten color
        if (!(bg ? sb.bg_pal_set[entry] : sb.obj_pal_set[entry]))
            send_item(write_item(bg ? OP_BG_PAL_WR : OP_OBJ_PAL_WR,
                                 {7'($urandom), entry}, 16'($urandom)));
        send_item(it);
    endtask

    // stop offering and let every expected pixel come out before touching the registers
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // both canvas registers back to back, valid held high across the pair
    task automatic set_canvas_size(logic [9:0] w, logic [9:0] h);
        cfg_index <= CFG_CANVAS_WIDTH;
        cfg_data  <= w;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_canvas(CFG_CANVAS_WIDTH, w);
        cfg_index <= CFG_CANVAS_HEIGHT;
        cfg_data  <= h;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_canvas(CFG_CANVAS_HEIGHT, h);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // random traffic: mostly draws with their store setup, plus raw writes and ignored codes
    task automatic random_phase(int count);
        comp_item_t it;
        int         pick;
        for (int n = 0; n < count; n++)
        begin
            // switch idling on and off in stretches
            if (n % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            it   = random_item();
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                it.opcode = $urandom_range(0, 1) ? OP_DRAW_OBJ : OP_DRAW_BG;
                // a few hot tiles so draws revisit bytes that were written earlier
                if ($urandom_range(0, 3) != 0)
                    it.first_tile = $urandom_range(0, 1) ? 10'($urandom_range(0, 7))
                                                         : 10'($urandom_range(1016, 1023));
                it.dest_x = pick_coord(sb.canvas_w);
                it.dest_y = pick_coord(sb.canvas_h);
                draw_pixel(it);
            end
            else if (pick < 75)
            begin
                it.opcode = $urandom_range(0, 1) ? OP_OBJ_TILE_WR : OP_BG_TILE_WR;
                send_item(it);
            end
            else if (pick < 88)
            begin
                it.opcode = $urandom_range(0, 1) ? OP_OBJ_PAL_WR : OP_BG_PAL_WR;
                send_item(it);
            end
            else
            begin
                it.opcode = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
                send_item(it);
            end
        end
    endtask

    // result side: random stall per item, two long holds to fill the pipeline
    initial
    begin : result_sink
        int     gap;
        pixel_t got;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            got = '{pixel_write, pixel_x, pixel_y, pixel_color};
            sb.check_pixel(got);
            // the sender keeps offering meanwhile, so the input must stall
            if (sb.results_checked == 150 || sb.results_checked == 550)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
        end
    end

    // hard limit well beyond the slowest correct run
    initial
    begin : watchdog
        #20_000_000;
        $display("tile_sprite_pixel_compositor_tb: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [14:0] a;
        int          widths  [6];
        int          heights [6];
        int          failures;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        opcode        <= OP_OBJ_TILE_WR;
        write_address <= '0;
        write_data    <= '0;
        local_x       <= '0;
        local_y       <= '0;
        dest_x        <= '0;
        dest_y        <= '0;
        first_tile    <= '0;
        pal_bank      <= '0;
        under_pixel   <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_CANVAS_WIDTH;
        cfg_data      <= '0;
        sb            = new();
        idle_on       = 1'b0;

        // largest, smallest, zero width, zero height, random, back to the reset size
        widths  = '{1023, 1, 0, 300, $urandom_range(1, 1023), 240};
        heights = '{1023, 1, 400, 0, $urandom_range(1, 1023), 160};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opaque object pixels at the top of the tile range, with wrap of the tile index
        a = tile_byte_addr(1'b0, 10'd1023, 5'd31, 5'd31);
        send_item(write_item(OP_OBJ_TILE_WR, a, 16'hAAF1));
        // palette address with all upper bits set, color with the unused top bit set
        send_item(write_item(OP_OBJ_PAL_WR, 15'h7FFF, 16'hFFFF));
        send_item(write_item(OP_OBJ_PAL_WR, 15'h00F1, 16'h8000));
        draw_pixel(draw_item(OP_DRAW_OBJ, 5'd31, 5'd31, 10'd1023, 4'd15,
                             11'sd0, 11'sd0, 24'h000000));
        draw_pixel(draw_item(OP_DRAW_OBJ, 5'd30, 5'd31, 10'd1023, 4'd15,
                             11'sd239, 11'sd159, 24'hFFFFFF));

        // clipped: negative, one past the edge, most negative, far positive
        draw_pixel(draw_item(OP_DRAW_OBJ, 5'd31, 5'd31, 10'd1023, 4'd15,
                             -11'sd1, 11'sd0, 24'h000000));
        draw_pixel(draw_item(OP_DRAW_OBJ, 5'd31, 5'd31, 10'd1023, 4'd15,
                             11'sd240, 11'sd5, 24'h000000));
        draw_pixel(draw_item(OP_DRAW_OBJ, 5'd31, 5'd31, 10'd1023, 4'd15,
                             11'sd5, 11'h400, 24'h000000));
        draw_pixel(draw_item(OP_DRAW_OBJ, 5'd31, 5'd31, 10'd1023, 4'd15,
                             11'sd5, 11'sd1023, 24'h000000));

        // background range tile blended over white and over black
        a = tile_byte_addr(1'b1, 10'd1023, 5'd31, 5'd31);
        send_item(write_item(OP_BG_TILE_WR, a, 16'h005A));
        send_item(write_item(OP_BG_PAL_WR, 15'h0075, 16'h7C1F));
        send_item(write_item(OP_BG_PAL_WR, 15'h007A, 16'h03E0));
        draw_pixel(draw_item(OP_DRAW_BG, 5'd31, 5'd31, 10'd1023, 4'd7,
                             11'sd100, 11'sd100, 24'hFFFFFF));
        draw_pixel(draw_item(OP_DRAW_BG, 5'd30, 5'd31, 10'd1023, 4'd7,
                             11'sd101, 11'sd100, 24'h000000));

        // transparent color index
        send_item(write_item(OP_OBJ_TILE_WR, 15'h0000, 16'hFF00));
        draw_pixel(draw_item(OP_DRAW_OBJ, 5'd0, 5'd0, 10'd0, 4'd0,
                             11'sd10, 11'sd10, 24'h000000));

        // ignored opcodes and a write to the last byte of a store
        send_item(write_item(OP_UNUSED_A, 15'h1234, 16'h5678));
        send_item(write_item(OP_UNUSED_B, 15'h7FFF, 16'hFFFF));
        send_item(write_item(OP_BG_TILE_WR, 15'h7FFF, 16'hFFFF));

        // random traffic at the reset canvas, then one phase per canvas setting
        random_phase(100);
        for (int p = 0; p < 6; p++)
        begin
            drain_pipeline();
            set_canvas_size(10'(widths[p]), 10'(heights[p]));
            random_phase(50);
        end

        // everything out, then a few more cycles for stray results
        drain_pipeline();
        repeat (10) @(posedge clk);

        failures = sb.mismatches + sb.pending_pixels.size();
        $display("run covered %0d items with %0d draws, %0d of them painting a pixel,",
                 items_sent, sb.draws_seen, sb.pixels_drawn);
        $display("across %0d canvas settings and %0d long output holds; %0d mismatches",
                 settings_used + 1, holds_done, failures);
        if (failures == 0)
            $display("tile_sprite_pixel_compositor_tb: PASS");
        else
            $display("tile_sprite_pixel_compositor_tb: FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/tspc_pkg.sv
hw/rtl/tspc_ram.sv
hw/rtl/tile_sprite_pixel_compositor.sv
hw/rtl/tspc_checker.sv
verif/tile_sprite_pixel_compositor_tb.sv
